FILE: design/lsod_pkg.sv
// Shared types and constants for the laser segment obstacle detector.
// No dependencies; lsod_track, lsod_decide and the top-level unit import this package.
package lsod_pkg;

  // Fixed field widths
  localparam int RANGE_W    = 16;
  localparam int MIN_IDX_W  = 10;
  localparam int SHORT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_MIN = 3'd0,
    CFG_RANGE_MAX = 3'd1,
    CFG_JUMP      = 3'd2,
    CFG_NEAR      = 3'd3,
    CFG_MIN_INDEX = 3'd4,
    CFG_SHORT_LEN = 3'd5
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [RANGE_W-1:0]   RANGE_MIN_RST = 16'd100;
  localparam logic [RANGE_W-1:0]   RANGE_MAX_RST = 16'd30000;
  localparam logic [RANGE_W-1:0]   JUMP_RST      = 16'd300;
  localparam logic [RANGE_W-1:0]   NEAR_RST      = 16'd700;
  localparam logic [MIN_IDX_W-1:0] MIN_INDEX_RST = 10'd30;
  localparam logic [SHORT_W-1:0]   SHORT_LEN_RST = 11'd15;

  // Input word
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               last_in_scan;
  } sample_t;

  // Result word
  typedef struct packed {
    logic obstacle;
    logic decided;
  } result_t;

  // Configuration register file contents
  typedef struct packed {
    logic [RANGE_W-1:0]   range_min_mm;
    logic [RANGE_W-1:0]   range_max_mm;
    logic [RANGE_W-1:0]   jump_mm;
    logic [RANGE_W-1:0]   near_mm;
    logic [MIN_IDX_W-1:0] min_index;
    logic [SHORT_W-1:0]   short_len;
  } cfg_t;

  // Tracker to decision stage: one accepted word and whether it closes a segment
  typedef struct packed {
    logic load;
    logic decide;
  } dec_req_t;

endpackage

FILE: design/lsod_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lsod_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lsod_track.sv
// Segment tracker: classifies each accepted sample, keeps the segment state and
// drives the segment store write and the middle-entry read. Uses lsod_pkg.
module lsod_track import lsod_pkg::*; #(
  parameter int SCAN_LEN = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cfg_t                        cfg,
  input  sample_t                     sample,
  input  logic                        accept,
  output logic                        ram_we,
  output logic [$clog2(SCAN_LEN)-1:0] ram_waddr,
  output logic [$clog2(SCAN_LEN)-1:0] ram_widx,
  output logic [RANGE_W-1:0]          ram_wrange,
  output logic                        ram_re,
  output logic [$clog2(SCAN_LEN)-1:0] ram_raddr,
  output dec_req_t                    req
);

  localparam int IDX_W = $clog2(SCAN_LEN);
  localparam int CNT_W = $clog2(SCAN_LEN + 1);
  localparam int CMP_W = (CNT_W > SHORT_W) ? CNT_W : SHORT_W;

  logic [CNT_W-1:0]   count, count_next;
  logic               in_seg, in_seg_next;
  logic [RANGE_W-1:0] prev_range;
  logic [IDX_W-1:0]   sample_idx, sample_idx_next;

  logic               in_range, rise, fall, push, decide, is_short, not_full;
  logic [RANGE_W:0]   up_d, down_d;

  // Neighbor step and validity
  always_comb begin
    in_range = (sample.range_mm >= cfg.range_min_mm) && (sample.range_mm <= cfg.range_max_mm);
    up_d     = {1'b0, sample.range_mm} - {1'b0, prev_range};
    down_d   = {1'b0, prev_range} - {1'b0, sample.range_mm};
    rise     = !up_d[RANGE_W] && (up_d[RANGE_W-1:0] > cfg.jump_mm);
    fall     = !down_d[RANGE_W] && (down_d[RANGE_W-1:0] > cfg.jump_mm);
    is_short = CMP_W'(count) < CMP_W'(cfg.short_len);
    not_full = count < CNT_W'(SCAN_LEN);
  end

  // Segment decisions for the accepted word
  always_comb begin
    count_next      = count;
    in_seg_next     = in_seg;
    sample_idx_next = sample_idx;
    push            = 1'b0;
    decide          = 1'b0;
    if (accept) begin
      if (!in_range) begin
        if (in_seg) begin
          decide      = 1'b1;
          count_next  = '0;
          in_seg_next = 1'b0;
        end
      end else if (in_seg) begin
        if (rise || (fall && is_short)) begin
          count_next  = '0;
          in_seg_next = 1'b0;
        end else if (!fall) begin
          push = 1'b1;
        end
      end else begin
        push        = 1'b1;
        in_seg_next = 1'b1;
      end
      // count saturates at the store depth
      if (push && not_full) begin
        count_next = count + CNT_W'(1);
      end
      // end of scan clears the segment; only an out-of-range closing word still decides
      if (sample.last_in_scan) begin
        count_next      = '0;
        in_seg_next     = 1'b0;
        sample_idx_next = '0;
      end else if (sample_idx == IDX_W'(SCAN_LEN - 1)) begin
        sample_idx_next = '0;
      end else begin
        sample_idx_next = sample_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      in_seg     <= 1'b0;
      prev_range <= '0;
      sample_idx <= '0;
    end else begin
      count      <= count_next;
      in_seg     <= in_seg_next;
      sample_idx <= sample_idx_next;
      if (accept) begin
        prev_range <= sample.range_mm;
      end
    end
  end

  // Store port: a closing word never writes, so no same-cycle collision
  assign ram_we     = push && not_full;
  assign ram_waddr  = count[IDX_W-1:0];
  assign ram_widx   = sample_idx;
  assign ram_wrange = sample.range_mm;
  assign ram_re     = decide;
  assign ram_raddr  = IDX_W'(count >> 1);

  assign req.load   = accept;
  assign req.decide = decide;

endmodule

FILE: design/lsod_decide.sv
// Decision stage and result register: evaluates the middle entry read from the
// segment store, holds the obstacle flag and drives the result channel. Uses lsod_pkg.
module lsod_decide import lsod_pkg::*; #(
  parameter int IDX_W = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  dec_req_t           req,
  input  logic [IDX_W-1:0]   mid_idx,
  input  logic [RANGE_W-1:0] mid_range,
  input  logic               result_stall,
  output logic               result_valid,
  output result_t            result,
  output logic               hold
);

  localparam int CMP_W = (IDX_W > MIN_IDX_W) ? IDX_W : MIN_IDX_W;

  logic s1_valid, s1_dec;
  logic advance, flag, flag_new;

  // Stage 1 moves on when the result register is free or being emptied
  assign advance = s1_valid && !(result_valid && result_stall);
  assign hold    = s1_valid && result_valid && result_stall;

  always_comb begin
    flag_new = flag;
    if (s1_dec) begin
      flag_new = (CMP_W'(mid_idx) > CMP_W'(cfg.min_index)) && (mid_range < cfg.near_mm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s1_dec       <= 1'b0;
      result_valid <= 1'b0;
      flag         <= 1'b0;
    end else begin
      if (req.load) begin
        s1_valid <= 1'b1;
        s1_dec   <= req.decide;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        flag         <= flag_new;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result.obstacle <= flag_new;
      result.decided  <= s1_dec;
    end
  end

endmodule

FILE: design/laser_segment_obstacle_detect_unit.sv
// Laser segment obstacle detector. Takes one range word per cycle while not
// stalled and returns one result word per input word via the stage-1 and result
// registers. Throughput is one word per clock when neither side stalls: the only
// memory access per word is one write (append to segment) or one read (middle
// entry on segment close) of the segment store, a one-port-each RAM of SCAN_LEN
// entries. The store needs no clearing pass after reset. Configuration registers
// are written through cfg_write/cfg_index/cfg_data; the user must do so only
// while the block is idle (not enforced); writes to indexes above 5 are ignored.
// Depends on lsod_pkg, lsod_ram, lsod_track, lsod_decide.
module laser_segment_obstacle_detect_unit import lsod_pkg::*; #(
  parameter int SCAN_LEN = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(SCAN_LEN);
  localparam int ENT_W = IDX_W + RANGE_W;

  cfg_t               cfg;
  logic               accept, hold;
  dec_req_t           req;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr, ram_widx;
  logic [RANGE_W-1:0] ram_wrange;
  logic [ENT_W-1:0]   ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_min_mm <= RANGE_MIN_RST;
      cfg.range_max_mm <= RANGE_MAX_RST;
      cfg.jump_mm      <= JUMP_RST;
      cfg.near_mm      <= NEAR_RST;
      cfg.min_index    <= MIN_INDEX_RST;
      cfg.short_len    <= SHORT_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_idx_e'(cfg_index))
        CFG_RANGE_MIN: cfg.range_min_mm <= cfg_data;
        CFG_RANGE_MAX: cfg.range_max_mm <= cfg_data;
        CFG_JUMP:      cfg.jump_mm      <= cfg_data;
        CFG_NEAR:      cfg.near_mm      <= cfg_data;
        CFG_MIN_INDEX: cfg.min_index    <= cfg_data[MIN_IDX_W-1:0];
        CFG_SHORT_LEN: cfg.short_len    <= cfg_data[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign sample_stall = hold;
  assign accept       = sample_valid && !hold;

  lsod_track #(
    .SCAN_LEN(SCAN_LEN)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample    (sample),
    .accept    (accept),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_widx  (ram_widx),
    .ram_wrange(ram_wrange),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .req       (req)
  );

  // Segment store: {sample index, range}
  lsod_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SCAN_LEN)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({ram_widx, ram_wrange}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lsod_decide #(
    .IDX_W(IDX_W)
  ) u_decide (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req         (req),
    .mid_idx     (ram_rdata[ENT_W-1:RANGE_W]),
    .mid_range   (ram_rdata[RANGE_W-1:0]),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result),
    .hold        (hold)
  );

endmodule
